>>> rtl/rqws_pkg.sv
// package for the ready queue with wait statistics
// status codes, action codes and shared constants; no dependencies
package rqws_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_SPARE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_POPPED  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_SAMPLED = 3'd4
    } t_status;

    localparam logic [31:0] MIN_WAIT_RESET = 32'd100000;
    localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;
    localparam logic [4:0]  LIMIT_RESET    = 5'd16;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] exec_time;
        logic [1:0]  cpu_index;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] task_time;
        logic [31:0] task_wait;
        logic [4:0]  queue_count;
        logic [31:0] drop_count;
        logic [4:0]  avg_occupancy;
        logic [31:0] cpu_max_wait;
        logic [31:0] cpu_min_wait;
        logic [31:0] cpu_avg_wait;
        logic [31:0] cpu_tasks;
    } t_rsp;

endpackage

>>> rtl/rqws_if.sv
// valid/ready channel interfaces for request and result
// depends on rqws_pkg
interface rqws_req_if;
    logic           valid;
    logic           ready;
    rqws_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rqws_rsp_if;
    logic           valid;
    logic           ready;
    rqws_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rqws_div.sv
// restoring serial divider, 64-bit numerator by 33-bit divisor, 32-bit quotient
// depends on nothing; one quotient bit per cycle
module rqws_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [33:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_sh;
    logic [34:0] w_diff;

    // shift in next numerator bit and trial subtract
    assign w_sh   = {r_rem[32:0], r_num[63]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_diff[34]) begin
                    r_rem <= w_diff[33:0];
                end else begin
                    r_rem <= w_sh;
                end
                r_num <= {r_num[62:0], !w_diff[34]};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient fits 32 bits since average never exceeds max value
    assign o_done = r_done;
    assign o_quot = r_num[31:0];
endmodule

>>> rtl/ready_queue_with_wait_stats.sv
// top level of the ready queue with wait statistics
// depends on rqws_pkg, rqws_if and rqws_div
//
//  channel   dir  handshake       payload
//  i_req     in   valid/ready     action, exec_time, cpu_index, now
//  o_rsp     out  valid/ready     status .. cpu_tasks
//  cfg       in   i_cfg_we        queue_limit (5 bits)
//
// push, drop, empty pop and pop for an unknown consumer go from accept through
// read, execute and output back to idle; pop for a known consumer and sample
// also pass through the divide state, set by the shared 64-step serial divider.
// reset is synchronous; no clearing pass, slot memory is left unwritten.
// one request at a time; a stalled result holds until taken, then ready rises.
module ready_queue_with_wait_stats #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int NUM_CONSUMERS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_wdata,
    rqws_req_if.sink        i_req,
    rqws_rsp_if.source      o_rsp
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_mem_exec [QUEUE_DEPTH];
    logic [31:0] r_mem_arr  [QUEUE_DEPTH];
    logic [31:0] r_rd_exec, r_rd_arr;

    logic [4:0]    r_limit;
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_occ;
    logic [31:0]   r_drop, r_samples;
    logic [4:0]    r_occ_avg;
    logic [31:0]   r_max [NUM_CONSUMERS];
    logic [31:0]   r_min [NUM_CONSUMERS];
    logic [31:0]   r_avg [NUM_CONSUMERS];
    logic [31:0]   r_cnt [NUM_CONSUMERS];

    rqws_pkg::t_req r_req;
    logic [2:0]     r_status;
    logic [31:0]    r_task, r_wait;
    logic           r_div_mode;  // 1 wait average, 0 occupancy average
    rqws_pkg::t_rsp w_rsp;

    logic [PW:0]   w_lim;
    logic          w_cpu_ok;
    logic [CW-1:0] w_ci;
    logic          w_start;
    logic [63:0]   w_num;
    logic [32:0]   w_den;
    logic [31:0]   w_mul_a, w_mul_b;
    logic          w_done;
    logic [31:0]   w_quot;
    logic [31:0]   w_wait;

    // effective ring size, clamped to 1..QUEUE_DEPTH
    always_comb begin
        if (r_limit == 5'd0) begin
            w_lim = (PW+1)'(1);
        end else if (32'(r_limit) > 32'(QUEUE_DEPTH)) begin
            w_lim = (PW+1)'(QUEUE_DEPTH);
        end else begin
            w_lim = (PW+1)'(r_limit);
        end
    end

    assign w_cpu_ok = 32'(r_req.cpu_index) < 32'(NUM_CONSUMERS);
    assign w_ci     = w_cpu_ok ? CW'(r_req.cpu_index) : '0;
    assign w_wait   = r_req.now - r_rd_arr;

    // divider operands: old average times count plus new value
    assign w_mul_a = r_div_mode ? r_avg[w_ci] : {27'd0, r_occ_avg};
    assign w_mul_b = r_div_mode ? r_cnt[w_ci] : r_samples;
    assign w_num   = 64'(w_mul_a) * 64'(w_mul_b)
                   + 64'(r_div_mode ? w_wait : 32'(r_occ));
    assign w_den   = {1'b0, w_mul_b} + 33'd1;
    assign w_start = (r_state == S_EXEC)
                   && ((r_status == rqws_pkg::ST_SAMPLED)
                       || (r_status == rqws_pkg::ST_POPPED && w_cpu_ok));

    rqws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    // slot memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_req.action == rqws_pkg::ACT_PUSH
            && r_occ < w_lim) begin
            r_mem_exec[r_wp] <= r_req.exec_time;
            r_mem_arr[r_wp]  <= r_req.now;
        end
        r_rd_exec <= r_mem_exec[r_rp];
        r_rd_arr  <= r_mem_arr[r_rp];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = w_start ? S_DIV : S_OUT;
            S_DIV:   if (w_done) n_state = S_OUT;
            S_OUT:   if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // queue and statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= rqws_pkg::LIMIT_RESET;
            r_wp      <= '0;
            r_rp      <= '0;
            r_occ     <= '0;
            r_drop    <= '0;
            r_samples <= '0;
            r_occ_avg <= '0;
            for (int k = 0; k < NUM_CONSUMERS; k++) begin
                r_max[k] <= '0;
                r_min[k] <= rqws_pkg::MIN_WAIT_RESET;
                r_avg[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
                r_wp    <= '0;
                r_rp    <= '0;
                r_occ   <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) r_req <= i_req.data;
                end
                S_READ: begin
                    r_task <= '0;
                    r_wait <= '0;
                    case (r_req.action)
                        rqws_pkg::ACT_PUSH: begin
                            if (r_occ >= w_lim) begin
                                r_status <= rqws_pkg::ST_DROPPED;
                                if (r_drop != rqws_pkg::SAT32) r_drop <= r_drop + 32'd1;
                            end else begin
                                r_status <= rqws_pkg::ST_PUSHED;
                                r_wp  <= ((PW+1)'(r_wp) + (PW+1)'(1) >= w_lim)
                                       ? '0 : r_wp + PW'(1);
                                r_occ <= r_occ + (PW+1)'(1);
                            end
                        end
                        rqws_pkg::ACT_POP: begin
                            r_status   <= (r_occ == '0) ? rqws_pkg::ST_EMPTY
                                                        : rqws_pkg::ST_POPPED;
                            r_div_mode <= 1'b1;
                        end
                        default: begin
                            r_status   <= rqws_pkg::ST_SAMPLED;
                            r_div_mode <= 1'b0;
                        end
                    endcase
                end
                S_EXEC: begin
                    if (r_status == rqws_pkg::ST_POPPED) begin
                        r_task <= r_rd_exec;
                        r_wait <= w_wait;
                        r_rp   <= ((PW+1)'(r_rp) + (PW+1)'(1) >= w_lim)
                                ? '0 : r_rp + PW'(1);
                        r_occ  <= r_occ - (PW+1)'(1);
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        if (r_div_mode) begin
                            if (r_wait > r_max[w_ci]) r_max[w_ci] <= r_wait;
                            if (r_wait < r_min[w_ci]) r_min[w_ci] <= r_wait;
                            r_avg[w_ci] <= w_quot;
                            if (r_cnt[w_ci] != rqws_pkg::SAT32)
                                r_cnt[w_ci] <= r_cnt[w_ci] + 32'd1;
                        end else begin
                            r_occ_avg <= w_quot[4:0];
                            if (r_samples != rqws_pkg::SAT32)
                                r_samples <= r_samples + 32'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result assembly
    always_comb begin
        w_rsp.status        = r_status;
        w_rsp.task_time     = r_task;
        w_rsp.task_wait     = r_wait;
        w_rsp.queue_count   = 5'(r_occ);
        w_rsp.drop_count    = r_drop;
        w_rsp.avg_occupancy = r_occ_avg;
        w_rsp.cpu_max_wait  = w_cpu_ok ? r_max[w_ci] : '0;
        w_rsp.cpu_min_wait  = w_cpu_ok ? r_min[w_ci] : '0;
        w_rsp.cpu_avg_wait  = w_cpu_ok ? r_avg[w_ci] : '0;
        w_rsp.cpu_tasks     = w_cpu_ok ? r_cnt[w_ci] : '0;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = w_rsp;

    // divider runs only in its own state
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> $past(r_state == S_DIV))
        else $error("divider finished outside divide state");
    // occupancy never exceeds depth
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= 32'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");
    // result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> o_rsp.valid)
        else $error("result dropped");
endmodule
